FILE: rtl/pixel_format_to_bgra8_assert.svh
// assertion macros used by the port-level checker of the pixel format converter
`ifndef PIXEL_FORMAT_TO_BGRA8_ASSERT_SVH
`define PIXEL_FORMAT_TO_BGRA8_ASSERT_SVH

// clocked assertion, masked while reset is active
`define PFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PFB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pfb_pkg.sv
// shared types, codes and arithmetic for the pixel format converter
`default_nettype none

package pfb_pkg;

    localparam int unsigned ByteWidth     = 8;
    localparam int unsigned SrcBytes      = 4;
    localparam int unsigned DataWidth     = ByteWidth * SrcBytes;
    localparam int unsigned FormatWidth   = 3;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 3;

    localparam logic [ByteWidth-1:0] ChannelMax = 8'hFF;
    localparam logic [ByteWidth-1:0] ChannelMin = 8'h00;

    typedef enum logic [FormatWidth-1:0] {
        FMT_XRGB32   = 3'd0,
        FMT_ARGB32   = 3'd1,
        FMT_RGB555   = 3'd2,
        FMT_ARGB1555 = 3'd3,
        FMT_RGB565   = 3'd4,
        FMT_RGB24    = 3'd5
    } src_format_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SOURCE_FORMAT = 2'd0,
        CFG_BIG_ENDIAN    = 2'd1,
        CFG_PREMULTIPLY   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [FormatWidth-1:0] source_format;
        logic                   big_endian;
        logic                   premultiply;
    } cfg_t;

    // blue in the low byte, alpha in the high byte
    typedef struct packed {
        logic [ByteWidth-1:0] alpha;
        logic [ByteWidth-1:0] red;
        logic [ByteWidth-1:0] green;
        logic [ByteWidth-1:0] blue;
    } bgra_t;

    // floor(c * a / 255), exact for every 16-bit product
    function automatic logic [ByteWidth-1:0] premul_div255(
        input logic [ByteWidth-1:0] c,
        input logic [ByteWidth-1:0] a
    );
        logic [2*ByteWidth-1:0] prod;
        logic [2*ByteWidth:0]   sum;
        prod = 16'(c) * 16'(a);
        sum  = {1'b0, prod} + 17'(prod[2*ByteWidth-1:ByteWidth]) + 17'd1;
        return sum[2*ByteWidth-1:ByteWidth];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfb_cfg_regs.sv
// configuration register file of the pixel format converter
`default_nettype none

module pfb_cfg_regs
    import pfb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SOURCE_FORMAT: cfg_next.source_format = cfg_wdata;
                CFG_BIG_ENDIAN:    cfg_next.big_endian    = cfg_wdata[0];
                CFG_PREMULTIPLY:   cfg_next.premultiply   = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format <= FMT_XRGB32;
            cfg_reg.big_endian    <= 1'b1;
            cfg_reg.premultiply   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/pfb_convert.sv
// unpacks one source pixel and builds the bgra8 result
`default_nettype none

module pfb_convert
    import pfb_pkg::*;
(
    input  wire cfg_t            cfg,
    input  wire logic [DataWidth-1:0] src,
    output bgra_t                pix
);

    logic [ByteWidth-1:0]   b0, b1, b2, b3;
    logic [2*ByteWidth-1:0] word;
    bgra_t                  res;

    assign b0 = src[ByteWidth-1:0];
    assign b1 = src[2*ByteWidth-1:ByteWidth];
    assign b2 = src[3*ByteWidth-1:2*ByteWidth];
    assign b3 = src[4*ByteWidth-1:3*ByteWidth];

    assign word = cfg.big_endian ? {b0, b1} : {b1, b0};

    always_comb begin
        res       = '0;
        res.alpha = ChannelMax;
        unique case (cfg.source_format) inside
            FMT_ARGB32: begin
                if (cfg.big_endian) begin
                    res.alpha = b0;
                    res.red   = b1;
                    res.green = b2;
                    res.blue  = b3;
                end else begin
                    res.alpha = b3;
                    res.red   = b2;
                    res.green = b1;
                    res.blue  = b0;
                end
                if (cfg.premultiply) begin
                    res.red   = premul_div255(res.red, res.alpha);
                    res.green = premul_div255(res.green, res.alpha);
                    res.blue  = premul_div255(res.blue, res.alpha);
                end
            end
            FMT_RGB555, FMT_ARGB1555: begin
                res.red   = {word[14:10], 3'b000};
                res.green = {word[9:5], 3'b000};
                res.blue  = {word[4:0], 3'b000};
                if (cfg.source_format == FMT_ARGB1555) begin
                    res.alpha = word[15] ? ChannelMax : ChannelMin;
                    // clear alpha bit zeroes the colour when premultiplying
                    if (cfg.premultiply && !word[15]) begin
                        res.red   = ChannelMin;
                        res.green = ChannelMin;
                        res.blue  = ChannelMin;
                    end
                end
            end
            FMT_RGB565: begin
                res.red   = {word[15:11], 3'b000};
                res.green = {word[10:5], 2'b00};
                res.blue  = {word[4:0], 3'b000};
            end
            FMT_RGB24: begin
                if (cfg.big_endian) begin
                    res.red   = b0;
                    res.green = b1;
                    res.blue  = b2;
                end else begin
                    res.red   = b2;
                    res.green = b1;
                    res.blue  = b0;
                end
            end
            default: begin
                // xrgb32 and unassigned codes
                if (cfg.big_endian) begin
                    res.red   = b1;
                    res.green = b2;
                    res.blue  = b3;
                end else begin
                    res.red   = b2;
                    res.green = b1;
                    res.blue  = b0;
                end
            end
        endcase
    end

    assign pix = res;

endmodule

`default_nettype wire

FILE: rtl/pixel_format_to_bgra8.sv
// Pixel format converter: raw source pixels in, BGRA 8:8:8:8 pixels out.
// s_tdata carries the four source bytes in memory order, byte 0 lowest;
// m_tdata carries blue, green, red, alpha from the lowest byte up.
// One result request is produced for every accepted source request.
// The cfg port writes source format, byte order and premultiply, one
// register per write; change it only while no request is in flight.
// A request passes through one input register, the conversion logic, then
// one output register before m_tvalid. Throughput is one pixel per cycle
// while m_tready stays high, set by the single conversion stage with its
// three 8x8 premultiply multipliers.
// When m_tready is low the output register holds its request and the input
// register can still take one more, so s_tready drops only when both are
// full. Synchronous active-low reset empties both registers and restores
// xRGB32, big-endian, premultiply off.
`default_nettype none

module pixel_format_to_bgra8
    import pfb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // src_byte_0, src_byte_1, src_byte_2, src_byte_3
    input  wire logic [DataWidth-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // blue_out, green_out, red_out, alpha_out
    output logic [DataWidth-1:0]          m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata
);

    cfg_t                 cfg;
    bgra_t                conv_pix;
    logic                 out_ready;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [DataWidth-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bgra_t                out_data_reg;

    pfb_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pfb_convert u_convert (
        .cfg (cfg),
        .src (in_data_reg),
        .pix (conv_pix)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (out_ready && in_valid_reg) begin
            out_data_reg <= conv_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/pfb_checker.sv
// port-level checker for the pixel format converter, bound to the top level
`default_nettype none

`include "pixel_format_to_bgra8_assert.svh"

module pfb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // reset leaves no result pending
    `PFB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // an accepted request is followed by a valid request at the output
    `PFB_ASSERT(a_latency, aclk, aresetn, s_tvalid && s_tready |=> ##1 m_tvalid, "request lost")

    // an empty output register never blocks the input
    `PFB_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled")

    // a stalled result holds
    `PFB_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed")

endmodule

bind pixel_format_to_bgra8 pfb_checker u_pfb_checker (.*);

`default_nettype wire

FILE: tb/sv/bgra8_checker.sv
// checker for the bgra8 converter: predicts each output pixel from the accepted source request
module bgra8_checker
    import pfb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [DataWidth-1:0]     s_tdata,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [DataWidth-1:0]     m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
    output int                            fail_count,
    output int                            outstanding
);

    localparam int ReportLimit = 10;

    cfg_t  active_cfg;
    bgra_t expected_pixels[$];
    int    errors;

    function automatic logic [ByteWidth-1:0] scale_by_alpha(
        input logic [ByteWidth-1:0] ch,
        input logic [ByteWidth-1:0] a
    );
        int unsigned prod;
        prod = 32'(ch) * 32'(a);
        return 8'(prod / 255);
    endfunction

    function automatic bgra_t convert_pixel(input logic [DataWidth-1:0] px, input cfg_t c);
        logic [ByteWidth-1:0] b0, b1, b2, b3;
        logic [15:0]          word;
        bgra_t                o;
        b0   = px[7:0];
        b1   = px[15:8];
        b2   = px[23:16];
        b3   = px[31:24];
        word = c.big_endian ? {b0, b1} : {b1, b0};
        o.alpha = ChannelMax;
        case (c.source_format)
            FMT_ARGB32: begin
                o = c.big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
                if (c.premultiply) begin
                    o.red   = scale_by_alpha(o.red, o.alpha);
                    o.green = scale_by_alpha(o.green, o.alpha);
                    o.blue  = scale_by_alpha(o.blue, o.alpha);
                end
            end
            FMT_RGB555, FMT_ARGB1555: begin
                o.red   = {word[14:10], 3'b000};
                o.green = {word[9:5], 3'b000};
                o.blue  = {word[4:0], 3'b000};
                if (c.source_format == FMT_ARGB1555) begin
                    o.alpha = word[15] ? ChannelMax : ChannelMin;
                    if (c.premultiply && !word[15]) begin
                        o.red   = ChannelMin;
                        o.green = ChannelMin;
                        o.blue  = ChannelMin;
                    end
                end
            end
            FMT_RGB565: begin
                o.red   = {word[15:11], 3'b000};
                o.green = {word[10:5], 2'b00};
                o.blue  = {word[4:0], 3'b000};
            end
            FMT_RGB24: begin
                o.red   = c.big_endian ? b0 : b2;
                o.green = b1;
                o.blue  = c.big_endian ? b2 : b0;
            end
            // xrgb32 and the spare codes
            default: begin
                o.red   = c.big_endian ? b1 : b2;
                o.green = c.big_endian ? b2 : b1;
                o.blue  = c.big_endian ? b3 : b0;
            end
        endcase
        return o;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= ReportLimit) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        bgra_t want;
        string names [4];
        names = '{"blue", "green", "red", "alpha"};
        if (!aresetn) begin
            active_cfg = '{source_format: FMT_XRGB32, big_endian: 1'b1, premultiply: 1'b0};
            expected_pixels.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (expected_pixels.size() == 0) begin
                    note_failure($sformatf("unexpected result request %h", m_tdata));
                end else begin
                    want = expected_pixels.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (m_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                            note_failure($sformatf("%s expected %h got %h", names[i],
                                                   want[8*i +: 8], m_tdata[8*i +: 8]));
                        end
                    end
                end
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
                expected_pixels.push_back(convert_pixel(s_tdata, active_cfg));
            end
            if (cfg_we === 1'b1) begin
                case (cfg_addr)
                    CFG_SOURCE_FORMAT: active_cfg.source_format = cfg_wdata[FormatWidth-1:0];
                    CFG_BIG_ENDIAN:    active_cfg.big_endian = cfg_wdata[0];
                    CFG_PREMULTIPLY:   active_cfg.premultiply = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        fail_count  <= errors;
        outstanding <= expected_pixels.size();
    end

endmodule

FILE: tb/sv/tb.sv
// testbench top for the bgra8 converter: stimulus, back-pressure and verdict
module tb;
    import pfb_pkg::*;

    localparam int TimeoutCycles  = 200000;
    localparam int HoldCycles     = 200;
    localparam int RandomPhases   = 12;
    localparam int PixelsPerPhase = 42;

    localparam logic [CfgIndexWidth-1:0] CfgSpareIndex = 2'd3;
    localparam logic [FormatWidth-1:0]   FmtSpareLo    = 3'd6;
    localparam logic [FormatWidth-1:0]   FmtSpareHi    = 3'd7;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [DataWidth-1:0]     s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DataWidth-1:0]     m_tdata;
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_addr  = CFG_SOURCE_FORMAT;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    bit src_idle     = 1'b1;
    bit sink_idle    = 1'b1;
    bit hold_request = 1'b0;

    always #1 aclk = ~aclk;

    pixel_format_to_bgra8 uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bgra8_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TimeoutCycles) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [DataWidth-1:0] px);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // drop valid and wait for every pending pixel to come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_registers(
        input logic [CfgDataWidth-1:0] fmt,
        input logic [CfgDataWidth-1:0] big,
        input logic [CfgDataWidth-1:0] pm
    );
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SOURCE_FORMAT;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_addr  <= CFG_BIG_ENDIAN;
        cfg_wdata <= big;
        @(posedge aclk);
        cfg_addr  <= CFG_PREMULTIPLY;
        cfg_wdata <= pm;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // output side: random stalls plus one long hold-off on request
    initial begin
        int unsigned stall;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HoldCycles;
            end else begin
                stall = sink_idle ? $urandom_range(0, 8) : 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        logic [DataWidth-1:0] px;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: xrgb32, big-endian
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0403_0201);
        wait_idle();

        write_registers(FMT_ARGB32, 3'd1, 3'd1);
        send_pixel(32'hFFFF_FF00);
        send_pixel(32'h00FF_80FF);
        send_pixel(32'h7F40_FF80);
        wait_idle();

        // only the low bit counts: little-endian, premultiply on
        write_registers(FMT_ARGB32, 3'b110, 3'b011);
        send_pixel(32'h80FF_7F01);
        send_pixel(32'h00FF_FFFF);
        wait_idle();

        write_registers(FMT_ARGB1555, 3'd1, 3'd1);
        send_pixel(32'h0000_FF7F);
        send_pixel(32'h0000_FFFF);
        wait_idle();

        write_registers(FMT_ARGB1555, 3'd0, 3'd0);
        send_pixel(32'hFFFF_7FFF);
        wait_idle();

        write_registers(FMT_RGB555, 3'd1, 3'd1);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'hAA55_7C1F);
        wait_idle();

        write_registers(FMT_RGB565, 3'd0, 3'd0);
        send_pixel(32'h0000_F81F);
        send_pixel(32'hFFFF_07E0);
        wait_idle();

        write_registers(FMT_RGB24, 3'd1, 3'd0);
        send_pixel(32'hFF12_3456);
        wait_idle();

        write_registers(FMT_RGB24, 3'd0, 3'd0);
        send_pixel(32'hEE12_3456);
        wait_idle();

        // write to an index with no register behind it
        cfg_we    <= 1'b1;
        cfg_addr  <= CfgSpareIndex;
        cfg_wdata <= 3'b111;
        @(posedge aclk);
        cfg_we    <= 1'b0;

        write_registers(FMT_XRGB32, 3'd0, 3'd1);
        send_pixel(32'h0080_4020);
        wait_idle();

        write_registers(FmtSpareLo, 3'd1, 3'd1);
        send_pixel(32'h8040_2010);
        wait_idle();

        write_registers(FmtSpareHi, 3'd0, 3'd0);
        send_pixel(32'h1020_4080);

        for (int phase = 0; phase < RandomPhases; phase++) begin
            wait_idle();
            write_registers(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)));
            if (phase == 0) begin
                src_idle     = 1'b0;
                sink_idle    = 1'b1;
                hold_request = 1'b1;
            end else begin
                src_idle  = ($urandom_range(0, 2) != 0);
                sink_idle = ($urandom_range(0, 2) != 0);
            end
            for (int n = 0; n < PixelsPerPhase; n++) begin
                px = $urandom();
                // alpha bytes at their extremes now and then
                case ($urandom_range(0, 7))
                    0: px[7:0]   = 8'h00;
                    1: px[7:0]   = 8'hFF;
                    2: px[31:24] = 8'h00;
                    3: px[31:24] = 8'hFF;
                    default: ;
                endcase
                send_pixel(px);
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_cfg_regs.sv
rtl/pfb_convert.sv
rtl/pixel_format_to_bgra8.sv
rtl/pfb_checker.sv
tb/sv/bgra8_checker.sv
tb/sv/tb.sv
